@@ sv/ecsfb_pkg.sv @@
// ----------------------------------------------------------------------------
// ecsfb_pkg: shared types and constants of the sorted free block table
// Entry, scan and command records passed between the sequencer and the
// cell chain, plus operation, status and sequencer state codes.
// ----------------------------------------------------------------------------
package ecsfb_pkg;

    localparam int BLOCK_W    = 16;
    localparam int COUNT_W    = 32;
    localparam int DIE_W      = 3;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int THRESH_W   = 16;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    localparam int ENTRIES_DEF   = 128;
    localparam int DIE_COUNT_DEF = 4;

    localparam logic [BLOCK_W-1:0]  NO_BLOCK        = '1;
    localparam logic [COUNT_W-1:0]  NO_COUNT        = '1;
    localparam logic [THRESH_W-1:0] WL_THRESHOLD_RST = 16'd100;

    typedef enum logic [OP_W-1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_SWAP = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_NO_FREE = 2'd1,
        STAT_NO_SWAP = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_FINISH
    } seq_state_t;

    // One table slot. The die number is kept next to the block so that a
    // get compares a few bits per cell instead of reducing the block id.
    typedef struct packed {
        logic [DIE_W-1:0]   die;
        logic [BLOCK_W-1:0] blk;
        logic [COUNT_W-1:0] cnt;
    } entry_t;

    // Scan token travelling up the chain one cell per cycle.
    typedef struct packed {
        logic   tok;
        logic   found;
        entry_t ent;
    } scan_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic   put;
        logic   swap;
        logic   get;
        logic   hit;
        logic   scan_swap;
        entry_t ent;
    } cmd_t;

    localparam entry_t EMPTY_ENTRY = '{die: '1, blk: NO_BLOCK, cnt: NO_COUNT};

endpackage

@@ sv/ecsfb_cell.sv @@
// ----------------------------------------------------------------------------
// ecsfb_cell: one slot of the sorted free block chain
// Holds one entry, shifts it up or down on a commit, and forwards the scan
// token with the entry it has selected so far.
// ----------------------------------------------------------------------------
module ecsfb_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  ecsfb_pkg::cmd_t   cmd,
    input  logic             tail,
    input  ecsfb_pkg::entry_t left_ent,
    input  logic             left_gt,
    input  ecsfb_pkg::entry_t right_ent,
    input  ecsfb_pkg::scan_t  scan_in,
    output ecsfb_pkg::entry_t ent,
    output logic             gt,
    output ecsfb_pkg::scan_t  scan_out
);

    ecsfb_pkg::entry_t ent_reg;
    ecsfb_pkg::entry_t ent_next;
    ecsfb_pkg::entry_t sel_reg;
    logic              tok_reg;
    logic              found_reg;
    logic              valid;
    logic              gt_eff;
    logic              take;

    assign valid  = (ent_reg.cnt != ecsfb_pkg::NO_COUNT);
    assign gt     = (ent_reg.cnt > cmd.ent.cnt);
    // The tail slot is always the insert point when nothing below it is.
    assign gt_eff = gt | tail;
    assign take   = valid && (cmd.scan_swap || (!scan_in.found && (ent_reg.die == cmd.ent.die)));

    always_comb
    begin
        ent_next = ent_reg;
        if (cmd.put || (cmd.swap && valid))
        begin
            if (left_gt)
            begin
                ent_next = left_ent;
            end
            else if (gt_eff)
            begin
                ent_next = cmd.ent;
            end
        end
        else if (cmd.get)
        begin
            if (!cmd.hit || found_reg)
            begin
                ent_next = right_ent;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= ecsfb_pkg::EMPTY_ENTRY;
            tok_reg <= 1'b0;
        end
        else
        begin
            ent_reg <= ent_next;
            tok_reg <= scan_in.tok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_in.tok)
        begin
            found_reg <= scan_in.found | take;
            sel_reg   <= take ? ent_reg : scan_in.ent;
        end
    end

    assign ent      = ent_reg;
    assign scan_out = '{tok: tok_reg, found: found_reg, ent: sel_reg};

endmodule

@@ sv/ecsfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ecsfb_ctrl: request sequencer of the sorted free block table
// Captures requests, launches the chain scan, decides the commit and holds
// the response register and the wear leveling threshold.
// ----------------------------------------------------------------------------
module ecsfb_ctrl #(
    parameter int DIE_COUNT = ecsfb_pkg::DIE_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ecsfb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [ecsfb_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ecsfb_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [ecsfb_pkg::STATUS_W-1:0]      m_axis_tuser,
    input  logic                               cfg_we,
    input  logic [ecsfb_pkg::THRESH_W-1:0]      cfg_wdata,
    input  ecsfb_pkg::entry_t                   head_ent,
    input  ecsfb_pkg::scan_t                    scan_last,
    output ecsfb_pkg::cmd_t                     cmd,
    output logic                               scan_start
);

    localparam int BW = ecsfb_pkg::BLOCK_W;
    localparam int CW = ecsfb_pkg::COUNT_W;
    localparam int DW = ecsfb_pkg::DIE_W;
    // Block id modulo DIE_COUNT by reciprocal: exact for 16-bit ids and
    // divisors up to eight with a shift of id width plus three.
    localparam int RECIP_SH = BW + 3;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = BW + RECIP_W;
    localparam longint RECIP = ((64'd1 << RECIP_SH) + DIE_COUNT - 1) / DIE_COUNT;
    localparam logic [BW+DW-1:0] DIV_EXT = (BW + DW)'(DIE_COUNT);
    localparam logic [DW:0]      DIV_N   = (DW + 1)'(DIE_COUNT);

    ecsfb_pkg::seq_state_t state_reg;
    ecsfb_pkg::seq_state_t state_next;

    logic [ecsfb_pkg::OP_W-1:0]     req_op_reg;
    logic [BW-1:0]                  req_blk_reg;
    logic [CW-1:0]                  req_cnt_reg;
    logic [DW-1:0]                  req_die_reg;
    logic [BW-1:0]                  req_q_reg;
    logic [ecsfb_pkg::THRESH_W-1:0] thr_reg;
    logic                           out_valid_reg;
    logic [ecsfb_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [ecsfb_pkg::STATUS_W-1:0] out_user_reg;

    logic [PROD_W-1:0]  q_prod;
    logic [BW+DW-1:0]   blk_diff;
    logic [DW-1:0]      blk_die;
    logic               accept;
    logic               fire;
    logic               item_ok;
    logic               nonempty;
    logic               swap_ok;
    logic [CW-1:0]      gap;
    ecsfb_pkg::entry_t  get_ent;
    logic [BW-1:0]      res_blk;
    logic [CW-1:0]      res_cnt;
    ecsfb_pkg::status_t res_st;

    function automatic logic [DW-1:0] die_mod(input logic [DW-1:0] x);
        logic [DW:0] r;
        r = {1'b0, x};
        for (int k = 0; k < 8; k++)
        begin
            if (r >= DIV_N)
            begin
                r = r - DIV_N;
            end
        end
        return r[DW-1:0];
    endfunction

    assign accept = s_axis_tvalid && s_axis_tready;
    assign q_prod = PROD_W'(s_axis_tdata[BW-1:0]) * PROD_W'(RECIP);

    // Remainder from the registered quotient.
    assign blk_diff = {{DW{1'b0}}, req_blk_reg} - ({{DW{1'b0}}, req_q_reg} * DIV_EXT);
    assign blk_die  = blk_diff[DW-1:0];

    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        scan_start    = 1'b0;
        unique case (state_reg)
            ecsfb_pkg::S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if ((s_axis_tuser == ecsfb_pkg::OP_GET) ||
                        (s_axis_tuser == ecsfb_pkg::OP_SWAP))
                    begin
                        state_next = ecsfb_pkg::S_START;
                    end
                    else
                    begin
                        state_next = ecsfb_pkg::S_FINISH;
                    end
                end
            end
            ecsfb_pkg::S_START:
            begin
                scan_start = 1'b1;
                state_next = ecsfb_pkg::S_SCAN;
            end
            ecsfb_pkg::S_SCAN:
            begin
                if (scan_last.tok)
                begin
                    state_next = ecsfb_pkg::S_FINISH;
                end
            end
            ecsfb_pkg::S_FINISH:
            begin
                if (fire)
                begin
                    state_next = ecsfb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ecsfb_pkg::S_IDLE;
            end
        endcase
    end

    assign fire     = (state_reg == ecsfb_pkg::S_FINISH) && (!out_valid_reg || m_axis_tready);
    assign item_ok  = (req_blk_reg != ecsfb_pkg::NO_BLOCK) && (req_cnt_reg != ecsfb_pkg::NO_COUNT);
    assign nonempty = (head_ent.cnt != ecsfb_pkg::NO_COUNT);
    assign gap      = scan_last.ent.cnt - req_cnt_reg;
    assign swap_ok  = scan_last.found && (req_blk_reg != ecsfb_pkg::NO_BLOCK) &&
                      (scan_last.ent.cnt > req_cnt_reg) &&
                      (gap > {{(CW - ecsfb_pkg::THRESH_W){1'b0}}, thr_reg});
    // No block on the requested die falls back to the head slot.
    assign get_ent  = scan_last.found ? scan_last.ent : head_ent;

    always_comb
    begin
        res_blk = ecsfb_pkg::NO_BLOCK;
        res_cnt = '0;
        res_st  = ecsfb_pkg::STAT_DONE;
        case (req_op_reg)
            ecsfb_pkg::OP_GET:
            begin
                if (nonempty)
                begin
                    res_blk = get_ent.blk;
                    res_cnt = get_ent.cnt + CW'(1);
                end
                else
                begin
                    res_st = ecsfb_pkg::STAT_NO_FREE;
                end
            end
            ecsfb_pkg::OP_SWAP:
            begin
                if (swap_ok)
                begin
                    res_blk = scan_last.ent.blk;
                    res_cnt = scan_last.ent.cnt;
                end
                else
                begin
                    res_st = ecsfb_pkg::STAT_NO_SWAP;
                end
            end
            default:
            begin
                res_st = ecsfb_pkg::STAT_DONE;
            end
        endcase
    end

    always_comb
    begin
        cmd.put       = fire && (req_op_reg == ecsfb_pkg::OP_PUT) && item_ok;
        cmd.swap      = fire && (req_op_reg == ecsfb_pkg::OP_SWAP) && swap_ok;
        cmd.get       = fire && (req_op_reg == ecsfb_pkg::OP_GET) && nonempty;
        cmd.hit       = scan_last.found;
        cmd.scan_swap = (req_op_reg == ecsfb_pkg::OP_SWAP);
        cmd.ent.blk   = req_blk_reg;
        cmd.ent.cnt   = req_cnt_reg;
        cmd.ent.die   = (req_op_reg == ecsfb_pkg::OP_GET) ? req_die_reg : blk_die;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecsfb_pkg::S_IDLE;
            thr_reg       <= ecsfb_pkg::WL_THRESHOLD_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg  <= s_axis_tuser;
            req_blk_reg <= s_axis_tdata[BW-1:0];
            req_cnt_reg <= s_axis_tdata[BW+CW-1:BW];
            req_die_reg <= die_mod(s_axis_tdata[BW+CW+DW-1:BW+CW]);
            req_q_reg   <= q_prod[RECIP_SH+BW-1:RECIP_SH];
        end
        if (fire)
        begin
            out_data_reg <= {res_cnt, res_blk};
            out_user_reg <= res_st;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

@@ sv/ec_sorted_free_block_table.sv @@
// ----------------------------------------------------------------------------
// ec_sorted_free_block_table: free block pool sorted by erase count
// Put, get and static wear leveling swap over a chain of slot cells.
// ----------------------------------------------------------------------------
// Put and the unused op code go from the accept straight to the finish state,
// which loads the response register; the sequencer then returns to idle.
// Get and swap walk a scan token through all ENTRIES cells, one per cycle, and
// load the response in the finish state once the token leaves the top cell.
// One request is in flight at a time; a waiting response holds off the commit.
// Reset is asynchronous and empties every slot at once; no clearing pass.
//
// The table is a row of ENTRIES cells, slot 0 holding the lowest erase
// count. Valid slots form a sorted prefix; empty slots hold an all-ones
// block and count. A put needs no search: every cell compares its own
// count with the new one, and the first cell whose count is greater takes
// the new entry while the cells above it take their lower neighbor's entry,
// which drops the top slot. A get or swap first needs a search, so a token
// walks up the chain; each cell records whether the wanted slot lies at or
// below it and forwards the entry chosen so far. For a get that entry is
// the first one on the requested die; for a swap it is the last valid one,
// which holds the largest count. At the end of the walk the sequencer
// decides and broadcasts a single commit: a get shifts every cell at or
// above the chosen slot down by one, a swap inserts the new block in sorted
// order among the valid slots and overwrites the displaced top entry.
// ----------------------------------------------------------------------------
module ec_sorted_free_block_table #(
    parameter int ENTRIES   = ecsfb_pkg::ENTRIES_DEF,
    parameter int DIE_COUNT = ecsfb_pkg::DIE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0: block_id[15:0], wear_count[47:16], die_sel[50:48],
    // zero padding up to bit 55.
    input  logic [ecsfb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: op[1:0].
    input  logic [ecsfb_pkg::OP_W-1:0]       s_axis_tuser,
    // Response channel.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // Fields from bit 0: out_block[15:0], out_count[47:16].
    output logic [ecsfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status[1:0].
    output logic [ecsfb_pkg::STATUS_W-1:0]   m_axis_tuser,
    // Wear leveling threshold register.
    input  logic                            cfg_we,
    input  logic [ecsfb_pkg::THRESH_W-1:0]   cfg_wdata
);

    ecsfb_pkg::cmd_t   cmd;
    logic              scan_start;
    ecsfb_pkg::entry_t ent_w  [ENTRIES];
    logic              gt_w   [ENTRIES];
    ecsfb_pkg::scan_t  scan_w [ENTRIES];
    ecsfb_pkg::scan_t  scan_head;

    // The token enters slot 0 with nothing selected yet.
    assign scan_head = '{tok: scan_start, found: 1'b0, ent: ecsfb_pkg::EMPTY_ENTRY};

    ecsfb_ctrl #(
        .DIE_COUNT (DIE_COUNT)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .head_ent      (ent_w[0]),
        .scan_last     (scan_w[ENTRIES-1]),
        .cmd           (cmd),
        .scan_start    (scan_start)
    );

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        ecsfb_pkg::entry_t left_ent;
        logic              left_gt;
        ecsfb_pkg::entry_t right_ent;
        ecsfb_pkg::scan_t  scan_in;

        // Slot 0 has nothing below it; the top slot refills with an empty
        // entry when a get shifts the chain down.
        if (i == 0)
        begin : g_head
            assign left_ent = ecsfb_pkg::EMPTY_ENTRY;
            assign left_gt  = 1'b0;
            assign scan_in  = scan_head;
        end
        else
        begin : g_body
            assign left_ent = ent_w[i-1];
            assign left_gt  = gt_w[i-1];
            assign scan_in  = scan_w[i-1];
        end

        if (i == ENTRIES - 1)
        begin : g_top
            assign right_ent = ecsfb_pkg::EMPTY_ENTRY;
        end
        else
        begin : g_mid
            assign right_ent = ent_w[i+1];
        end

        ecsfb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .tail      ((i == ENTRIES - 1) ? 1'b1 : 1'b0),
            .left_ent  (left_ent),
            .left_gt   (left_gt),
            .right_ent (right_ent),
            .scan_in   (scan_in),
            .ent       (ent_w[i]),
            .gt        (gt_w[i]),
            .scan_out  (scan_w[i])
        );
    end

endmodule

@@ sv/ecsfb_checker.sv @@
// ----------------------------------------------------------------------------
// ecsfb_checker: port level checks of the sorted free block table
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ecsfb_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ecsfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [ecsfb_pkg::STATUS_W-1:0]   m_axis_tuser
);

    localparam logic [ecsfb_pkg::OUT_DATA_W-1:0] NONE_DATA =
        {{ecsfb_pkg::COUNT_W{1'b0}}, ecsfb_pkg::NO_BLOCK};

    // A stalled response keeps its value.
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("response changed while stalled");

    // Only one request is in flight, so an accept is never followed at once
    // by another.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in flight");

    a_empty_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ecsfb_pkg::STAT_NO_FREE) |->
            (m_axis_tdata == NONE_DATA))
        else $error("empty pool response carries a block");

    a_refused_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ecsfb_pkg::STAT_NO_SWAP) |->
            (m_axis_tdata == NONE_DATA))
        else $error("refused swap response carries a block");

    // A handed out or displaced block always comes with a nonzero count.
    a_block_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ecsfb_pkg::STAT_DONE) &&
            (m_axis_tdata[ecsfb_pkg::BLOCK_W-1:0] != ecsfb_pkg::NO_BLOCK) |->
            (m_axis_tdata[ecsfb_pkg::OUT_DATA_W-1:ecsfb_pkg::BLOCK_W] != '0))
        else $error("block returned with a zero count");

endmodule

bind ec_sorted_free_block_table ecsfb_checker u_ecsfb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ sim/free_pool_checker.sv @@
// ----------------------------------------------------------------------------
// free_pool_checker: response checker for the sorted free block table
// Watches the request, response and threshold ports, keeps its own copy of
// the pool, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module free_pool_checker #(
    parameter int ENTRIES   = ecsfb_pkg::ENTRIES_DEF,
    parameter int DIE_COUNT = ecsfb_pkg::DIE_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [ecsfb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [ecsfb_pkg::OP_W-1:0]       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [ecsfb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [ecsfb_pkg::STATUS_W-1:0]   m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [ecsfb_pkg::THRESH_W-1:0]   cfg_wdata,
    output int                               errors,
    output int                               pending
);
    import ecsfb_pkg::*;

    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        logic [COUNT_W-1:0] cnt;
        status_t            st;
    } pool_rsp_t;

    logic [BLOCK_W-1:0]  pool_blk [ENTRIES];
    logic [COUNT_W-1:0]  pool_cnt [ENTRIES];
    logic [THRESH_W-1:0] wl_thr;
    pool_rsp_t           due_results[$];

    // Open slot p by moving slots p..last-1 up one place, then fill it.
    function automatic void pool_insert(int p, int last, logic [BLOCK_W-1:0] blk,
                                        logic [COUNT_W-1:0] cnt);
        for (int i = last; i > p; i--)
        begin
            pool_blk[i] = pool_blk[i-1];
            pool_cnt[i] = pool_cnt[i-1];
        end
        pool_blk[p] = blk;
        pool_cnt[p] = cnt;
    endfunction

    // First slot below limit whose count is above cnt, else limit.
    function automatic int pool_slot_after(logic [COUNT_W-1:0] cnt, int limit);
        for (int i = 0; i < limit; i++)
        begin
            if (pool_cnt[i] > cnt)
                return i;
        end
        return limit;
    endfunction

    // Applies one request to the pool copy and returns its response.
    function automatic pool_rsp_t pool_apply(logic [OP_W-1:0] op, logic [BLOCK_W-1:0] blk,
                                             logic [COUNT_W-1:0] cnt,
                                             logic [DIE_W-1:0] die_sel);
        pool_rsp_t r;
        int        die;
        int        sel;
        int        top;
        r.blk = NO_BLOCK;
        r.cnt = '0;
        r.st  = STAT_DONE;
        die   = die_sel % DIE_COUNT;
        if (op == OP_PUT)
        begin
            if (blk != NO_BLOCK && cnt != NO_COUNT)
                pool_insert(pool_slot_after(cnt, ENTRIES - 1), ENTRIES - 1, blk, cnt);
        end
        else if (op == OP_GET)
        begin
            if (pool_cnt[0] == NO_COUNT)
                r.st = STAT_NO_FREE;
            else
            begin
                sel = 0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (pool_cnt[i] == NO_COUNT)
                        break;
                    if (pool_blk[i] % DIE_COUNT == die)
                    begin
                        sel = i;
                        break;
                    end
                end
                r.blk = pool_blk[sel];
                r.cnt = pool_cnt[sel] + 1'b1;
                for (int i = sel; i < ENTRIES - 1; i++)
                begin
                    pool_blk[i] = pool_blk[i+1];
                    pool_cnt[i] = pool_cnt[i+1];
                end
                pool_blk[ENTRIES-1] = NO_BLOCK;
                pool_cnt[ENTRIES-1] = NO_COUNT;
            end
        end
        else if (op == OP_SWAP)
        begin
            top = -1;
            for (int i = ENTRIES - 1; i >= 0; i--)
            begin
                if (pool_cnt[i] != NO_COUNT)
                begin
                    top = i;
                    break;
                end
            end
            if (top >= 0 && blk != NO_BLOCK && pool_cnt[top] > cnt &&
                pool_cnt[top] - cnt > wl_thr)
            begin
                r.blk = pool_blk[top];
                r.cnt = pool_cnt[top];
                pool_insert(pool_slot_after(cnt, top), top, blk, cnt);
            end
            else
                r.st = STAT_NO_SWAP;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pool_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                pool_blk[i] = NO_BLOCK;
                pool_cnt[i] = NO_COUNT;
            end
            wl_thr = WL_THRESHOLD_RST;
            due_results.delete();
            errors  = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
                wl_thr = cfg_wdata;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_results.size() == 0)
                begin
                    $error("response with nothing expected: out_block %0d", m_axis_tdata[15:0]);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_axis_tdata[15:0] !== want.blk)
                    begin
                        $error("out_block: expected %0d, actual %0d", want.blk,
                               m_axis_tdata[15:0]);
                        errors++;
                    end
                    if (m_axis_tdata[47:16] !== want.cnt)
                    begin
                        $error("out_count: expected %0d, actual %0d", want.cnt,
                               m_axis_tdata[47:16]);
                        errors++;
                    end
                    if (m_axis_tuser !== want.st)
                    begin
                        $error("status: expected %0d, actual %0d", want.st, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                due_results.push_back(pool_apply(s_axis_tuser, s_axis_tdata[15:0],
                                                 s_axis_tdata[47:16], s_axis_tdata[50:48]));
            pending <= due_results.size();
        end
    end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top level of the sorted free block table testbench
// Drives put, get and swap requests through directed and random phases under
// several wear leveling thresholds, with random idling and back pressure on
// both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import ecsfb_pkg::*;

    localparam int ENTRIES   = ENTRIES_DEF;
    localparam int DIE_COUNT = DIE_COUNT_DEF;

    // Op code three has no meaning; the block must answer it as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles without any accepted request or response before giving up. The
    // slowest quiet spell is a full scan stacked on the long response hold,
    // so this leaves a wide margin.
    localparam int IDLE_LIMIT = 5000;
    // Length of the one deliberate response hold, and the response count
    // at which it starts.
    localparam int RSP_HOLD    = 400;
    localparam int HOLD_AT_RSP = 120;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;
    logic                  cfg_we;
    logic [THRESH_W-1:0]   cfg_wdata;

    int  fails;
    int  due;
    int  quiet_cycles;
    // Set by the request side to suppress its random gaps for a stretch.
    bit  req_steady;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ec_sorted_free_block_table #(
        .ENTRIES   (ENTRIES),
        .DIE_COUNT (DIE_COUNT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    free_pool_checker #(
        .ENTRIES   (ENTRIES),
        .DIE_COUNT (DIE_COUNT)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .errors        (fails),
        .pending       (due)
    );

    // Offers one request and returns at the clock edge where it is taken.
    // Random gaps come first, each cycle idle with a chance of about 36 in
    // a hundred; valid stays high straight into the next request when no
    // gap is drawn.
    task automatic send_req(logic [OP_W-1:0] op, logic [BLOCK_W-1:0] blk,
                            logic [COUNT_W-1:0] cnt, logic [DIE_W-1:0] die_sel);
        while (!req_steady && $urandom_range(0, 99) < 36)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, die_sel, cnt, blk};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stops offering and waits until every predicted response has arrived,
    // which leaves the block idle since each request yields one response.
    task automatic drain_pool;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (due != 0)
            @(posedge clk);
    endtask

    // Threshold writes happen only on an idle block.
    task automatic write_threshold(logic [THRESH_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [BLOCK_W-1:0] pick_block;
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return NO_BLOCK;
        else if (r < 8)
            return BLOCK_W'(65534 - $urandom_range(0, 7));
        return BLOCK_W'($urandom_range(0, 65534));
    endfunction

    // Mostly small counts so that gaps sit near the threshold, with some
    // full-range and near-top values and the occasional invalid count.
    function automatic logic [COUNT_W-1:0] pick_count;
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 2000);
        else if (r < 85)
            return $urandom;
        else if (r < 97)
            return NO_COUNT - $urandom_range(1, 300);
        return NO_COUNT;
    endfunction

    // One random phase. The weights are percentages for put, get and swap;
    // what is left over goes to the unused op code. Requests from steady_lo
    // up to steady_hi are sent back to back.
    task automatic run_phase(int n, int put_w, int get_w, int swap_w,
                             int steady_lo, int steady_hi);
        int               r;
        logic [OP_W-1:0]  op;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < put_w)
                op = OP_PUT;
            else if (r < put_w + get_w)
                op = OP_GET;
            else if (r < put_w + get_w + swap_w)
                op = OP_SWAP;
            else
                op = OP_UNUSED;
            req_steady = (k >= steady_lo && k < steady_hi);
            send_req(op, pick_block(), pick_count(), DIE_W'($urandom_range(0, 7)));
        end
        req_steady = 1'b0;
        drain_pool();
    endtask

    // Request side: reset, directed cases at the reset threshold, then
    // random phases under several threshold settings, then the verdict.
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_PUT;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        req_steady     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pool: get has nothing, swap is refused, unused op is a no-op.
        send_req(OP_GET, 16'd3, 32'd0, 3'd0);
        send_req(OP_SWAP, 16'd3, 32'd0, 3'd0);
        send_req(OP_UNUSED, 16'd1, 32'd1, 3'd1);
        // Invalid puts leave the pool alone.
        send_req(OP_PUT, NO_BLOCK, 32'd5, 3'd0);
        send_req(OP_PUT, 16'd4, NO_COUNT, 3'd0);
        // Field extremes, and two equal counts that must keep arrival order.
        send_req(OP_PUT, 16'd0, 32'd0, 3'd0);
        send_req(OP_PUT, 16'd65534, NO_COUNT - 1, 3'd7);
        send_req(OP_PUT, 16'd5, 32'd50, 3'd0);
        send_req(OP_PUT, 16'd6, 32'd50, 3'd0);
        send_req(OP_PUT, 16'd7, 32'd10, 3'd0);
        // Die selection wraps modulo the die count; a die with no block
        // falls back to the lowest slot.
        send_req(OP_GET, 16'd0, 32'd0, 3'd5);
        send_req(OP_GET, 16'd0, 32'd0, 3'd7);
        send_req(OP_GET, 16'd0, 32'd0, 3'd1);
        // Swap refused for an invalid block, a count above the largest, and
        // a gap equal to the threshold; then one just above it goes through.
        send_req(OP_SWAP, NO_BLOCK, 32'd0, 3'd0);
        send_req(OP_SWAP, 16'd9, NO_COUNT, 3'd0);
        send_req(OP_SWAP, 16'd9, NO_COUNT - 1 - 100, 3'd0);
        send_req(OP_SWAP, 16'd9, NO_COUNT - 1 - 101, 3'd0);
        send_req(OP_GET, 16'd0, 32'd0, 3'd2);
        send_req(OP_GET, 16'd0, 32'd0, 3'd6);
        send_req(OP_GET, 16'd0, 32'd0, 3'd4);
        drain_pool();

        // Zero threshold, put heavy so the pool fills and overflows.
        write_threshold(16'd0);
        run_phase(220, 80, 10, 8, -1, -1);
        // Largest threshold: only wide gaps swap.
        write_threshold(16'hFFFF);
        run_phase(150, 40, 25, 32, -1, -1);
        // Get heavy phase that drains the pool, opening back to back.
        write_threshold(THRESH_W'($urandom_range(1, 3000)));
        run_phase(200, 25, 60, 12, 0, 120);
        write_threshold(THRESH_W'($urandom_range(0, 65535)));
        run_phase(230, 55, 20, 22, -1, -1);

        // A get or swap is still a full scan away at most; let any stray
        // response show up before the verdict.
        repeat (ENTRIES + 8) @(posedge clk);
        if (fails == 0 && due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Response side: random ready, one long hold once the block has
    // answered HOLD_AT_RSP requests, and a stretch of steady ready later.
    initial
    begin : rsp_side
        int rsp_seen;
        int hold_left;
        bit held;
        rsp_seen  = 0;
        hold_left = 0;
        held      = 1'b0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                rsp_seen++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!held && rsp_seen >= HOLD_AT_RSP)
            begin
                held      = 1'b1;
                hold_left = RSP_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (rsp_seen >= 250 && rsp_seen < 450)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 36);
        end
    end

    // Watchdog on progress: any accepted request or response restarts it.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

@@ files.f @@
sv/ecsfb_pkg.sv
sv/ecsfb_cell.sv
sv/ecsfb_ctrl.sv
sv/ec_sorted_free_block_table.sv
sv/ecsfb_checker.sv
sim/free_pool_checker.sv
sim/tb.sv
